// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Implication with the consequent checked in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== rtl/armt_pkg.sv =====
// ----------------------------------------------------------------------------
// armt_pkg
// Types, codes and sizes of the address region map table.
// ----------------------------------------------------------------------------
package armt_pkg;

    localparam int MAX_REGIONS_DEF = 16;

    localparam logic [3:0] MODE_LOOKUP   = 4'd0;
    localparam logic [3:0] MODE_ADD_MEM  = 4'd1;
    localparam logic [3:0] MODE_ADD_MMIO = 4'd2;
    localparam logic [3:0] MODE_MIRROR   = 4'd3;
    localparam logic [3:0] MODE_REMOVE   = 4'd4;
    localparam logic [3:0] MODE_EXACT    = 4'd5;
    localparam logic [3:0] MODE_CONTAINS = 4'd6;
    localparam logic [3:0] MODE_OVERLAPS = 4'd7;
    localparam logic [3:0] MODE_ROM      = 4'd8;

    localparam logic [3:0] KIND_ROM    = 4'd1;
    localparam logic [3:0] KIND_RAM    = 4'd2;
    localparam logic [3:0] KIND_MMIO   = 4'd4;
    localparam logic [3:0] KIND_MIRROR = 4'd8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_CONFLICT  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_OUTSIDE   = 3'd4;
    localparam logic [2:0] ST_ZERO      = 3'd5;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] last;
        logic [3:0]  flags;
        logic [31:0] backing;
        logic [7:0]  owner;
    } entry_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  index;
        logic [3:0]  kind;
        logic [31:0] start;
        logic [31:0] last;
        logic [31:0] host;
        logic [7:0]  device;
        logic [4:0]  removed;
    } result_t;

endpackage

// ===== rtl/address_region_map_table.sv =====
// ----------------------------------------------------------------------------
// address_region_map_table
// Ordered table of address regions held in one synchronous memory.
// ----------------------------------------------------------------------------
// A request scans the stored rows, one read a cycle, evaluates the last row read
// and then closes; on an empty table it closes without a read. A sorted insert
// then shifts the rows from the insert point up by one and places the new entry;
// a zero-length add, remove, exact, contains or overlaps request skips the scan.
// Throughput: one request at a time; a done result waits while the output
// register holds an unaccepted beat. Reset clears count and control state only.
module address_region_map_table #(
    parameter int MAX_REGIONS = armt_pkg::MAX_REGIONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  mode,
    input  logic [31:0] address,
    input  logic [31:0] length,
    input  logic [31:0] origin_address,
    input  logic [31:0] origin_offset,
    input  logic [31:0] backing_base,
    input  logic        memory_kind,
    input  logic [7:0]  device_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  entry_index,
    output logic [3:0]  entry_kind,
    output logic [31:0] entry_start,
    output logic [31:0] entry_end,
    output logic [31:0] host_location,
    output logic [7:0]  entry_device,
    output logic [4:0]  removed_count
);

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_PLACE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // Region table: one entry per row, read data registered.
    armt_pkg::entry_t mem [MAX_REGIONS];
    armt_pkg::entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    armt_pkg::entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;     // next row to read
    logic             pend_reg, pend_next;       // read data arrives this cycle
    logic [CNT_W-1:0] pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0] wj_reg, wj_next;           // compaction write pointer
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] hit_idx_reg, hit_idx_next;
    armt_pkg::entry_t hit_reg, hit_next;
    logic             conflict_reg, conflict_next;
    logic             posf_reg, posf_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    armt_pkg::result_t res_reg, res_next;
    armt_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    // Request held for the whole operation.
    logic [3:0]  rq_mode_reg;
    logic [31:0] rq_addr_reg, rq_last_reg, rq_len_reg, rq_org_reg;
    logic [31:0] rq_off_reg, rq_back_reg;
    logic        rq_kind_reg;
    logic [7:0]  rq_dev_reg;

    logic in_fire;
    logic zero_len;
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign zero_len = (length == 32'd0) &&
                      (mode == armt_pkg::MODE_ADD_MEM  || mode == armt_pkg::MODE_ADD_MMIO ||
                       mode == armt_pkg::MODE_REMOVE   || mode == armt_pkg::MODE_EXACT ||
                       mode == armt_pkg::MODE_CONTAINS || mode == armt_pkg::MODE_OVERLAPS);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rq_mode_reg <= mode;
            rq_addr_reg <= address;
            rq_last_reg <= address + length - 32'd1;
            rq_len_reg  <= length;
            rq_org_reg  <= origin_address;
            rq_off_reg  <= origin_offset;
            rq_back_reg <= backing_base;
            rq_kind_reg <= memory_kind;
            rq_dev_reg  <= device_id;
        end
        hit_reg <= hit_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // Per-row match terms on the row just read.
    armt_pkg::entry_t rd;
    logic m_cover, m_conflict, m_exact, m_contains, m_overlap, m_rom, m_remove, m_first;
    logic dev_ok;
    always_comb
    begin
        rd         = rd_data_reg;
        dev_ok     = (rq_dev_reg == 8'd0) || (rd.owner == rq_dev_reg);
        m_overlap  = (rq_last_reg >= rd.first) && (rq_addr_reg <= rd.last);
        m_contains = (rq_addr_reg >= rd.first) && (rq_last_reg <= rd.last);
        m_conflict = m_overlap || m_contains;
        m_exact    = (rd.first == rq_addr_reg) && (rd.last == rq_last_reg) && dev_ok;
        m_rom      = (rd.flags == armt_pkg::KIND_ROM);
        m_remove   = (rd.flags == armt_pkg::KIND_MMIO) && m_exact;
        if (rq_mode_reg == armt_pkg::MODE_MIRROR)
        begin
            m_cover = (rq_org_reg >= rd.first) && (rq_org_reg <= rd.last);
        end
        else
        begin
            m_cover = (rq_addr_reg >= rd.first) && (rq_addr_reg <= rd.last);
        end
        unique case (rq_mode_reg)
            armt_pkg::MODE_LOOKUP,
            armt_pkg::MODE_MIRROR:   m_first = m_cover;
            armt_pkg::MODE_EXACT:    m_first = m_exact;
            armt_pkg::MODE_CONTAINS: m_first = m_contains;
            armt_pkg::MODE_OVERLAPS: m_first = m_overlap;
            armt_pkg::MODE_ROM:      m_first = m_rom;
            default:                 m_first = 1'b0;
        endcase
    end

    // Mirror bound check, carried without 32-bit wrap.
    logic [32:0] mir_size;
    logic [33:0] mir_top;
    logic        mir_outside;
    always_comb
    begin
        if (rq_len_reg != 32'd0)
        begin
            mir_size = {1'b0, rq_len_reg};
        end
        else
        begin
            mir_size = {1'b0, hit_reg.last} - {1'b0, hit_reg.first} + 33'd1;
        end
        mir_top     = {2'b00, hit_reg.first} + {2'b00, rq_off_reg} + {1'b0, mir_size} - 34'd1;
        mir_outside = mir_top > {2'b00, hit_reg.last};
    end

    armt_pkg::entry_t new_mem, new_mmio, new_mirror;
    always_comb
    begin
        new_mem.first   = rq_addr_reg;
        new_mem.last    = rq_last_reg;
        new_mem.flags   = rq_kind_reg ? armt_pkg::KIND_RAM : armt_pkg::KIND_ROM;
        new_mem.backing = rq_back_reg;
        new_mem.owner   = 8'd0;
        new_mmio.first   = rq_addr_reg;
        new_mmio.last    = rq_last_reg;
        new_mmio.flags   = armt_pkg::KIND_MMIO;
        new_mmio.backing = 32'd0;
        new_mmio.owner   = rq_dev_reg;
        new_mirror.first   = rq_addr_reg;
        new_mirror.last    = rq_addr_reg + mir_size[31:0] - 32'd1;
        new_mirror.flags   = hit_reg.flags | armt_pkg::KIND_MIRROR;
        new_mirror.backing = hit_reg.backing + rq_off_reg;
        new_mirror.owner   = 8'd0;
    end

    function automatic armt_pkg::result_t entry_result(armt_pkg::entry_t e,
                                                       logic [3:0] idx);
        armt_pkg::result_t r;
        r         = '0;
        r.status  = armt_pkg::ST_OK;
        r.index   = idx;
        r.kind    = e.flags;
        r.start   = e.first;
        r.last    = e.last;
        r.device  = e.owner;
        return r;
    endfunction

    logic scan_end;
    assign scan_end = (issue_reg >= count_reg) && !pend_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        wj_next        = wj_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_next       = hit_reg;
        conflict_next  = conflict_reg;
        posf_next      = posf_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    issue_next    = '0;
                    wj_next       = '0;
                    removed_next  = '0;
                    found_next    = 1'b0;
                    hit_idx_next  = '0;
                    conflict_next = 1'b0;
                    posf_next     = 1'b0;
                    if (zero_len)
                    begin
                        res_next        = '0;
                        res_next.status = armt_pkg::ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read a cycle while rows remain.
                if (issue_reg < count_reg)
                begin
                    rd_addr       = issue_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg;
                    issue_next    = issue_reg + CNT_W'(1);
                end
                // Evaluate the row read last cycle.
                if (pend_reg)
                begin
                    if (!found_reg && m_first)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = pend_idx_reg;
                        hit_next     = rd_data_reg;
                    end
                    if (m_conflict)
                    begin
                        conflict_next = 1'b1;
                    end
                    if (!posf_reg && (rd_data_reg.first > rq_addr_reg))
                    begin
                        posf_next = 1'b1;
                        pos_next  = pend_idx_reg;
                    end
                    if (rq_mode_reg == armt_pkg::MODE_REMOVE)
                    begin
                        if (m_remove)
                        begin
                            removed_next = removed_reg + CNT_W'(1);
                        end
                        else
                        begin
                            // Compact: move the kept row down.
                            wr_en   = 1'b1;
                            wr_addr = wj_reg[IDX_W-1:0];
                            wr_data = rd_data_reg;
                            wj_next = wj_reg + CNT_W'(1);
                        end
                    end
                end
                if (scan_end)
                begin
                    res_next        = '0;
                    res_next.status = armt_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                    unique case (rq_mode_reg)
                        armt_pkg::MODE_LOOKUP:
                        begin
                            if (found_reg)
                            begin
                                res_next = entry_result(hit_reg, 4'(hit_idx_reg));
                                if ((hit_reg.flags & armt_pkg::KIND_MMIO) == 4'd0)
                                begin
                                    res_next.host = rq_addr_reg - hit_reg.first +
                                                    hit_reg.backing;
                                end
                            end
                        end
                        armt_pkg::MODE_EXACT,
                        armt_pkg::MODE_CONTAINS,
                        armt_pkg::MODE_OVERLAPS,
                        armt_pkg::MODE_ROM:
                        begin
                            if (found_reg)
                            begin
                                res_next = entry_result(hit_reg, 4'(hit_idx_reg));
                            end
                        end
                        armt_pkg::MODE_ADD_MEM,
                        armt_pkg::MODE_ADD_MMIO:
                        begin
                            priority if (conflict_reg)
                            begin
                                res_next.status = armt_pkg::ST_CONFLICT;
                            end
                            else if (count_reg >= MAX_CNT)
                            begin
                                res_next.status = armt_pkg::ST_FULL;
                            end
                            else if (rq_mode_reg == armt_pkg::MODE_ADD_MMIO)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = new_mmio;
                                count_next = count_reg + CNT_W'(1);
                                res_next   = entry_result(new_mmio, 4'(count_reg));
                            end
                            else
                            begin
                                // Shift rows from the insert point up by one.
                                if (!posf_reg)
                                begin
                                    pos_next = count_reg;
                                end
                                issue_next = count_reg;
                                state_next = S_SHIFT;
                            end
                        end
                        armt_pkg::MODE_MIRROR:
                        begin
                            priority if (!found_reg)
                            begin
                                res_next.status = armt_pkg::ST_NOT_FOUND;
                            end
                            else if (mir_outside)
                            begin
                                res_next.status = armt_pkg::ST_OUTSIDE;
                            end
                            else if (count_reg >= MAX_CNT)
                            begin
                                res_next.status = armt_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = new_mirror;
                                count_next = count_reg + CNT_W'(1);
                                res_next   = entry_result(new_mirror, 4'(count_reg));
                            end
                        end
                        armt_pkg::MODE_REMOVE:
                        begin
                            count_next       = wj_reg;
                            res_next.removed = 5'(removed_reg);
                            res_next.status  = (removed_reg != '0) ? armt_pkg::ST_OK
                                                                   : armt_pkg::ST_NOT_FOUND;
                        end
                        default:
                        begin
                            res_next.status = armt_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // issue_reg is the destination row; read the one below it.
                if (issue_reg > pos_reg)
                begin
                    rd_addr       = IDX_W'(issue_reg - CNT_W'(1));
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg;
                    issue_next    = issue_reg - CNT_W'(1);
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg[IDX_W-1:0];
                    wr_data = rd_data_reg;
                end
                if ((issue_reg <= pos_reg) && !pend_reg)
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[IDX_W-1:0];
                wr_data    = new_mem;
                count_next = count_reg + CNT_W'(1);
                res_next   = entry_result(new_mem, 4'(pos_reg));
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            wj_reg        <= '0;
            removed_reg   <= '0;
            found_reg     <= 1'b0;
            hit_idx_reg   <= '0;
            conflict_reg  <= 1'b0;
            posf_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            wj_reg        <= wj_next;
            removed_reg   <= removed_next;
            found_reg     <= found_next;
            hit_idx_reg   <= hit_idx_next;
            conflict_reg  <= conflict_next;
            posf_reg      <= posf_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign entry_index   = out_reg.index;
    assign entry_kind    = out_reg.kind;
    assign entry_start   = out_reg.start;
    assign entry_end     = out_reg.last;
    assign host_location = out_reg.host;
    assign entry_device  = out_reg.device;
    assign removed_count = out_reg.removed;

endmodule

// ===== rtl/armt_checker.sv =====
// ----------------------------------------------------------------------------
// armt_checker
// Port-level checks of the address region map table result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module armt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [3:0]  entry_index,
    input logic [3:0]  entry_kind,
    input logic [31:0] entry_start,
    input logic [31:0] entry_end,
    input logic [31:0] host_location,
    input logic [7:0]  entry_device,
    input logic [4:0]  removed_count
);

    // every result field reads zero on a failed request
    logic fail_clean;
    assign fail_clean = (entry_index == 4'd0) && (entry_kind == 4'd0) &&
                        (entry_start == 32'd0) && (entry_end == 32'd0) &&
                        (host_location == 32'd0) && (entry_device == 8'd0) &&
                        (removed_count == 5'd0);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status))
    `ASSERT_IMPLIES(a_status_range, clk, rst_n, out_valid, status <= armt_pkg::ST_ZERO)
    `ASSERT_IMPLIES(a_fail_clean, clk, rst_n, out_valid && (status != armt_pkg::ST_OK), fail_clean)
    `ASSERT_IMPLIES(a_mmio_no_host, clk, rst_n, out_valid && entry_kind[2], host_location == 32'd0)

endmodule

bind address_region_map_table armt_checker u_armt_checker (.*);
